[hdl/bse_pkg.sv]
package bse_pkg;

	localparam int MAX_VARS_DEF = 6;
	localparam int TT_W_MAX = 64;
	localparam int NVARS_W = 3;
	localparam int IDX_W = 6;
	localparam int COEF_W = 8;
	localparam int SIZE_W = 7;

	localparam logic FUNC_WALSH = 1'b0;
	localparam logic FUNC_AUTOCORR = 1'b1;

	// Bit x of entry k is bit k of x: the truth table of variable k.
	localparam logic [5:0][TT_W_MAX-1:0] VAR_MASK = '{
		64'hFFFF_FFFF_0000_0000,
		64'hFFFF_0000_FFFF_0000,
		64'hFF00_FF00_FF00_FF00,
		64'hF0F0_F0F0_F0F0_F0F0,
		64'hCCCC_CCCC_CCCC_CCCC,
		64'hAAAA_AAAA_AAAA_AAAA
	};

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic last;
		logic [SIZE_W-1:0] size;
	} tag_t;

endpackage

[hdl/bse_ifs.sv]
interface bse_in_if;
	logic valid;
	logic ready;
	logic [63:0] truth_table;
	logic [2:0] num_vars;
	logic func;

	modport source (output valid, truth_table, num_vars, func, input ready);
	modport sink (input valid, truth_table, num_vars, func, output ready);
endinterface

interface bse_out_if;
	logic valid;
	logic ready;
	logic signed [7:0] coefficient;
	logic [5:0] coeff_index;
	logic last;

	modport source (output valid, coefficient, coeff_index, last, input ready);
	modport sink (input valid, coefficient, coeff_index, last, output ready);
endinterface

[hdl/boolean_spectrum_engine.sv]
// Boolean spectrum engine.
// The input channel in_ch carries one truth table with its variable count and mode per
// transfer. The output channel out_ch returns 2^n coefficients for that table, in increasing
// index order, with last set on index 2^n-1. A variable count above MAX_VARS is taken as
// MAX_VARS.
// After a transfer on in_ch, ready stays low while the sequencer steps the row index through
// 2^n values, one per cycle while the output is not stalled. The row index steps a single
// shared mismatch and popcount unit, which has two register stages, so the first coefficient
// appears after those two registers, and the rest follow one per cycle while the output is
// not stalled.
// When the receiver holds ready low, the output register keeps its coefficient and the
// whole pipeline and the row counter stop until the transfer completes.
// Reset clears the sequencer and the pipeline valid bits; the block then accepts a new
// item at once.
module boolean_spectrum_engine #(
	parameter int MAX_VARS = bse_pkg::MAX_VARS_DEF
) (
	input logic clk,
	input logic arst_n,
	bse_in_if.sink in_ch,
	bse_out_if.source out_ch
);

	localparam int TT_W = 1 << MAX_VARS;
	localparam int W_W = MAX_VARS;

	logic busy_q;
	logic [W_W-1:0] w_q;
	logic [W_W-1:0] last_w_q;
	logic mode_q;
	logic [TT_W-1:0] tt_q;
	logic [TT_W-1:0] mask_q;
	logic [bse_pkg::SIZE_W-1:0] size_q;

	logic [bse_pkg::NVARS_W-1:0] n_sat;
	logic [TT_W-1:0] mask_d;
	logic [TT_W-1:0] perm_v;
	logic [TT_W-1:0] swap_v;
	logic [TT_W-1:0] lin_v;
	logic [TT_W-1:0] vec;
	logic in_xfer;
	logic issue;
	logic adv;
	bse_pkg::tag_t tag;

	assign in_ch.ready = !busy_q;
	assign in_xfer = in_ch.valid && !busy_q;
	assign issue = busy_q && adv;

	always_comb begin
		n_sat = (in_ch.num_vars > bse_pkg::NVARS_W'(MAX_VARS)) ?
			bse_pkg::NVARS_W'(MAX_VARS) : in_ch.num_vars;
		for (int x = 0; x < TT_W; x++) begin
			mask_d[x] = (x < (1 << n_sat));
		end
	end

	always_comb begin
		perm_v = tt_q;
		lin_v = '0;
		for (int k = 0; k < MAX_VARS; k++) begin
			swap_v = perm_v;
			if (w_q[k]) begin
				for (int x = 0; x < TT_W; x++) begin
					perm_v[x] = swap_v[x ^ (1 << k)];
				end
				lin_v = lin_v ^ bse_pkg::VAR_MASK[k][TT_W-1:0];
			end
		end
		vec = (tt_q ^ ((mode_q == bse_pkg::FUNC_AUTOCORR) ? perm_v : lin_v)) & mask_q;
	end

	assign tag.idx = bse_pkg::IDX_W'(w_q);
	assign tag.last = (w_q == last_w_q);
	assign tag.size = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			w_q <= '0;
		end else if (in_xfer) begin
			busy_q <= 1'b1;
			w_q <= '0;
		end else if (issue) begin
			w_q <= w_q + W_W'(1);
			if (w_q == last_w_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tt_q <= in_ch.truth_table[TT_W-1:0] & mask_d;
			mask_q <= mask_d;
			mode_q <= in_ch.func;
			last_w_q <= W_W'((32'd1 << n_sat) - 32'd1);
			size_q <= bse_pkg::SIZE_W'(32'd1 << n_sat);
		end
	end

	bse_coeff_unit #(
		.VEC_W(TT_W)
	) u_coeff (
		.clk(clk),
		.arst_n(arst_n),
		.issue(issue),
		.vec(vec),
		.tag(tag),
		.adv(adv),
		.out_ch(out_ch)
	);

endmodule

[hdl/bse_coeff_unit.sv]
module bse_coeff_unit #(
	parameter int VEC_W = bse_pkg::TT_W_MAX
) (
	input logic clk,
	input logic arst_n,
	input logic issue,
	input logic [VEC_W-1:0] vec,
	input bse_pkg::tag_t tag,
	output logic adv,
	bse_out_if.source out_ch
);

	localparam int CHUNK = (VEC_W < 8) ? VEC_W : 8;
	localparam int NCHUNK = VEC_W / CHUNK;
	localparam int CNT_W = $clog2(CHUNK + 1);
	localparam int POP_W = $clog2(VEC_W + 1);

	logic [NCHUNK-1:0][CNT_W-1:0] cnt_d;
	logic [NCHUNK-1:0][CNT_W-1:0] cnt_s1;
	logic valid_s1;
	bse_pkg::tag_t tag_s1;
	logic [POP_W-1:0] pop;
	logic [bse_pkg::COEF_W-1:0] coef_d;

	logic out_valid_q;
	logic [bse_pkg::COEF_W-1:0] coef_q;
	logic [bse_pkg::IDX_W-1:0] idx_q;
	logic last_q;

	assign adv = !out_valid_q || out_ch.ready;

	always_comb begin
		for (int c = 0; c < NCHUNK; c++) begin
			cnt_d[c] = '0;
			for (int b = 0; b < CHUNK; b++) begin
				cnt_d[c] = cnt_d[c] + CNT_W'(vec[c*CHUNK + b]);
			end
		end
	end

	always_comb begin
		pop = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			pop = pop + POP_W'(cnt_s1[c]);
		end
		coef_d = bse_pkg::COEF_W'(tag_s1.size) - bse_pkg::COEF_W'({pop, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && issue) begin
			cnt_s1 <= cnt_d;
			tag_s1 <= tag;
		end
		if (adv && valid_s1) begin
			coef_q <= coef_d;
			idx_q <= tag_s1.idx;
			last_q <= tag_s1.last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.coefficient = $signed(coef_q);
	assign out_ch.coeff_index = idx_q;
	assign out_ch.last = last_q;

endmodule

[hdl/bse_checker.sv]
module bse_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [7:0] coefficient,
	input logic [5:0] coeff_index,
	input logic last
);

	// A stalled result keeps its payload until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coefficient) &&
		$stable(coeff_index) && $stable(last))
		else $error("output changed while stalled");

	// An accepted table keeps the input closed on the next cycle.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input open right after a transfer");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (coefficient >= -8'sd64) && (coefficient <= 8'sd64))
		else $error("coefficient out of range");

	// Only a single-row spectrum, with no variables, can give an odd coefficient.
	a_coef_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(last && coeff_index == 6'd0) |-> !coefficient[0])
		else $error("odd coefficient with variables present");

endmodule

bind boolean_spectrum_engine bse_checker u_bse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.coefficient(out_ch.coefficient),
	.coeff_index(out_ch.coeff_index),
	.last(out_ch.last)
);
